>>> hdl/tcit_pkg.sv
// ----------------------------------------------------------------------------
// tcit_pkg
// Shared constants and types of the triangle circumcircle and incircle test
// unit: operand routing tables of the front end, divider sizes, output rails.
// ----------------------------------------------------------------------------
package tcit_pkg;

  localparam int NUM_COORD = 8;
  localparam int NUM_DIFF  = 14;
  localparam int NUM_PROD  = 24;
  localparam int NUM_SUM   = 12;

  // coordinate slots: ax ay bx by cx cy qx qy
  localparam int DIFF_POS [NUM_DIFF] = '{2, 3, 4, 5, 4, 5, 0, 1, 0, 1, 2, 3, 4, 5};
  localparam int DIFF_NEG [NUM_DIFF] = '{0, 1, 0, 1, 2, 3, 4, 5, 6, 7, 6, 7, 6, 7};

  // difference slots
  localparam int D_UX  = 0;
  localparam int D_UY  = 1;
  localparam int D_VX  = 2;
  localparam int D_VY  = 3;

  localparam int PROD_A [NUM_PROD] = '{0, 1, 0, 1, 2, 3, 8, 9, 10, 11, 12, 13,
                                       10, 12, 12, 8, 8, 10, 1, 0, 5, 4, 7, 6};
  localparam int PROD_B [NUM_PROD] = '{3, 2, 0, 1, 2, 3, 8, 9, 10, 11, 12, 13,
                                       13, 11, 9, 13, 11, 9, 10, 11, 12, 13, 8, 9};

  // sum k = prod 2k +/- prod 2k+1, bit k set for subtract
  localparam logic [NUM_SUM-1:0] SUM_SUB = 12'b1111_1100_0001;

  localparam int S_CROSS = 0;
  localparam int S_UU    = 1;
  localparam int S_VV    = 2;
  localparam int S_AL    = 3;
  localparam int S_BL    = 4;
  localparam int S_CL    = 5;
  localparam int S_M1    = 6;
  localparam int S_M2    = 7;
  localparam int S_M3    = 8;
  localparam int S_Z1    = 9;
  localparam int S_Z2    = 10;
  localparam int S_Z3    = 11;

  localparam int QUO_BITS = 33;
  localparam int DIV_LAT  = QUO_BITS + 3;
  localparam int AREA_W   = 34;

  localparam logic [QUO_BITS-1:0] QUO_POS_MAX = 33'h0_7FFF_FFFF;
  localparam logic [QUO_BITS-1:0] QUO_NEG_MAX = 33'h0_8000_0000;
  localparam logic signed [31:0]  CENTER_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]  CENTER_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              degen;
    logic              cross_neg;
    logic              in_tri;
    logic              in_circle;
  } side_t;

endpackage

>>> hdl/tcit_front.sv
// ----------------------------------------------------------------------------
// tcit_front
// Three register stages: coordinate differences, their products, and the
// pairwise sums (cross product, squared lengths, minors, edge tests).
// ----------------------------------------------------------------------------
module tcit_front #(
  parameter int COORD_WIDTH = 16,
  localparam int DFW = COORD_WIDTH + 1,
  localparam int PW  = 2 * COORD_WIDTH + 2,
  localparam int SW  = 2 * COORD_WIDTH + 3
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] coord [tcit_pkg::NUM_COORD],
  output logic signed [COORD_WIDTH-1:0] ax_out,
  output logic signed [COORD_WIDTH-1:0] ay_out,
  output logic signed [DFW-1:0]         diff_out [tcit_pkg::NUM_DIFF],
  output logic signed [SW-1:0]          sum_out [tcit_pkg::NUM_SUM]
);

  logic signed [DFW-1:0]         d1 [tcit_pkg::NUM_DIFF];
  logic signed [DFW-1:0]         d2 [tcit_pkg::NUM_DIFF];
  logic signed [PW-1:0]          p2 [tcit_pkg::NUM_PROD];
  logic signed [COORD_WIDTH-1:0] ax1, ay1, ax2, ay2;

  for (genvar k = 0; k < tcit_pkg::NUM_DIFF; k++) begin : g_diff
    always_ff @(posedge clk) begin
      if (en) begin
        d1[k] <= DFW'(coord[tcit_pkg::DIFF_POS[k]]) - DFW'(coord[tcit_pkg::DIFF_NEG[k]]);
        d2[k] <= d1[k];
        diff_out[k] <= d2[k];
      end
    end
  end

  for (genvar k = 0; k < tcit_pkg::NUM_PROD; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        p2[k] <= PW'(d1[tcit_pkg::PROD_A[k]]) * PW'(d1[tcit_pkg::PROD_B[k]]);
      end
    end
  end

  for (genvar k = 0; k < tcit_pkg::NUM_SUM; k++) begin : g_sum
    always_ff @(posedge clk) begin
      if (en) begin
        if (tcit_pkg::SUM_SUB[k]) begin
          sum_out[k] <= SW'(p2[2*k]) - SW'(p2[2*k+1]);
        end else begin
          sum_out[k] <= SW'(p2[2*k]) + SW'(p2[2*k+1]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1    <= coord[0];
      ay1    <= coord[1];
      ax2    <= ax1;
      ay2    <= ay1;
      ax_out <= ax2;
      ay_out <= ay2;
    end
  end

endmodule

>>> hdl/tcit_mul.sv
// ----------------------------------------------------------------------------
// tcit_mul
// Two-stage signed multiplier: four half-width partial products, then their
// shifted sum.
// ----------------------------------------------------------------------------
module tcit_mul #(
  parameter int AW = 16,
  parameter int BW = 16,
  localparam int PW = AW + BW
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [PW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;

  logic signed [AL:0]        a_lo;
  logic signed [BL:0]        b_lo;
  logic signed [AH-1:0]      a_hi;
  logic signed [BH-1:0]      b_hi;
  logic signed [AL+BL+1:0]   pp_ll;
  logic signed [AL+BH:0]     pp_lh;
  logic signed [AH+BL:0]     pp_hl;
  logic signed [AH+BH-1:0]   pp_hh;

  assign a_lo = $signed({1'b0, a[AL-1:0]});
  assign b_lo = $signed({1'b0, b[BL-1:0]});
  assign a_hi = a[AW-1:AL];
  assign b_hi = b[BW-1:BL];

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= (AL+BL+2)'(a_lo) * (AL+BL+2)'(b_lo);
      pp_lh <= (AL+BH+1)'(a_lo) * (AL+BH+1)'(b_hi);
      pp_hl <= (AH+BL+1)'(a_hi) * (AH+BL+1)'(b_lo);
      pp_hh <= (AH+BH)'(a_hi) * (AH+BH)'(b_hi);
      p     <= (PW'(pp_hh) <<< (AL + BL)) + (PW'(pp_hl) <<< AL)
             + (PW'(pp_lh) <<< BL) + PW'(pp_ll);
    end
  end

endmodule

>>> hdl/tcit_div.sv
// ----------------------------------------------------------------------------
// tcit_div
// Pipelined restoring divider: magnitudes, range check, one quotient bit per
// stage, then sign and 32-bit saturation. Quotient truncates toward zero.
// ----------------------------------------------------------------------------
module tcit_div #(
  parameter int NW = 55,
  parameter int DW = 36
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [31:0]   quo,
  output logic                 sat
);

  localparam int QB = tcit_pkg::QUO_BITS;
  localparam int RW = (NW > DW + QB) ? NW : DW + QB;

  logic [NW-1:0] num_mag;
  logic [DW-1:0] den_mag;
  logic          neg0;
  logic [NW-1:0] rem  [QB];
  logic [DW-1:0] dmv  [QB];
  logic [QB-1:0] q    [QB+1];
  logic          negv [QB+1];
  logic          ovfv [QB+1];
  logic          sat_c;
  logic [QB-1:0] qf;

  always_ff @(posedge clk) begin
    if (en) begin
      num_mag <= num[NW-1] ? NW'(-num) : NW'(num);
      den_mag <= den[DW-1] ? DW'(-den) : DW'(den);
      neg0    <= num[NW-1] ^ den[DW-1];
      rem[0]  <= num_mag;
      dmv[0]  <= den_mag;
      q[0]    <= '0;
      negv[0] <= neg0;
      ovfv[0] <= RW'(num_mag) >= (RW'(den_mag) << QB);
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [RW-1:0] sub_c;
    logic          ge_c;

    assign sub_c = RW'(dmv[i]) << (QB - 1 - i);
    assign ge_c  = RW'(rem[i]) >= sub_c;

    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1]    <= q[i] | (QB'(ge_c) << (QB - 1 - i));
        negv[i+1] <= negv[i];
        ovfv[i+1] <= ovfv[i];
      end
    end

    if (i < QB - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= ge_c ? NW'(RW'(rem[i]) - sub_c) : rem[i];
          dmv[i+1] <= dmv[i];
        end
      end
    end
  end

  assign qf    = q[QB];
  assign sat_c = ovfv[QB] || (negv[QB] ? (qf > tcit_pkg::QUO_NEG_MAX)
                                      : (qf > tcit_pkg::QUO_POS_MAX));

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= sat_c;
      if (negv[QB]) begin
        quo <= sat_c ? tcit_pkg::CENTER_MIN : $signed(~qf[31:0] + 32'd1);
      end else begin
        quo <= sat_c ? tcit_pkg::CENTER_MAX : $signed(qf[31:0]);
      end
    end
  end

endmodule

>>> hdl/triangle_circumcircle_incircle_test_unit.sv
// ----------------------------------------------------------------------------
// triangle_circumcircle_incircle_test_unit
// Circumcenter, incircle and point-in-triangle test for one triangle and one
// query point per word, with twice the triangle area.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | ax ay bx by cx cy qx qy
//  out     | out_valid / out_ready| center_x center_y center_saturated
//          |                      | degenerate in_circle in_triangle twice_area
//
//  One word enters per cycle unless the output stalls; latency is set by the
//  33-stage quotient pipeline behind three front stages and split multipliers.
//  Reset clears only the valid bits of the pipeline.
//  A stalled output word freezes every stage; in_ready is low only then.
// ----------------------------------------------------------------------------
module triangle_circumcircle_incircle_test_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] qx,
  input  logic signed [COORD_WIDTH-1:0] qy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            center_x,
  output logic signed [31:0]            center_y,
  output logic                          center_saturated,
  output logic                          degenerate,
  output logic                          in_circle,
  output logic                          in_triangle,
  output logic [tcit_pkg::AREA_W-1:0]   twice_area
);

  localparam int DFW   = COORD_WIDTH + 1;
  localparam int SW    = 2 * COORD_WIDTH + 3;
  localparam int DENW  = SW + 1;
  localparam int MW    = COORD_WIDTH + SW + 1;
  localparam int NW    = MW + 2;
  localparam int DTW   = 2 * SW + 2;
  localparam int DEPTH = tcit_pkg::DIV_LAT + 7;
  localparam int DL    = tcit_pkg::DIV_LAT;

  logic                          en;
  logic [DEPTH-1:0]              vpipe;
  logic signed [COORD_WIDTH-1:0] coord [tcit_pkg::NUM_COORD];
  logic signed [COORD_WIDTH-1:0] ax3, ay3;
  logic signed [DFW-1:0]         d3 [tcit_pkg::NUM_DIFF];
  logic signed [SW-1:0]          s3 [tcit_pkg::NUM_SUM];
  logic signed [DENW-1:0]        den3, den4, den5, den6;
  logic signed [MW-1:0]          t_axd, t_vyu, t_uyv, t_ayd, t_uxv, t_vxu;
  logic signed [2*SW-1:0]        t_a, t_b, t_c;
  logic signed [DTW-1:0]         det_c;
  logic signed [NW-1:0]          nx6, ny6;
  logic                          det_pos, det_neg;
  logic [SW-1:0]                 cross_mag;
  tcit_pkg::side_t               side_c, side6_c;
  tcit_pkg::side_t               side1 [3];
  tcit_pkg::side_t               side2 [DL];
  tcit_pkg::side_t               side_o;
  logic signed [31:0]            quo_x, quo_y;
  logic                          sat_x, sat_y;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vpipe[DEPTH-1];

  assign coord[0] = ax;
  assign coord[1] = ay;
  assign coord[2] = bx;
  assign coord[3] = by;
  assign coord[4] = cx;
  assign coord[5] = cy;
  assign coord[6] = qx;
  assign coord[7] = qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[DEPTH-2:0], in_valid};
    end
  end

  tcit_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .en       (en),
    .coord    (coord),
    .ax_out   (ax3),
    .ay_out   (ay3),
    .diff_out (d3),
    .sum_out  (s3)
  );

  assign den3 = {s3[tcit_pkg::S_CROSS], 1'b0};

  tcit_mul #(.AW(COORD_WIDTH), .BW(DENW)) u_mul_axd (
    .clk(clk), .en(en), .a(ax3), .b(den3), .p(t_axd));
  tcit_mul #(.AW(COORD_WIDTH), .BW(DENW)) u_mul_ayd (
    .clk(clk), .en(en), .a(ay3), .b(den3), .p(t_ayd));
  tcit_mul #(.AW(DFW), .BW(SW)) u_mul_vyu (
    .clk(clk), .en(en), .a(d3[tcit_pkg::D_VY]), .b(s3[tcit_pkg::S_UU]), .p(t_vyu));
  tcit_mul #(.AW(DFW), .BW(SW)) u_mul_uyv (
    .clk(clk), .en(en), .a(d3[tcit_pkg::D_UY]), .b(s3[tcit_pkg::S_VV]), .p(t_uyv));
  tcit_mul #(.AW(DFW), .BW(SW)) u_mul_uxv (
    .clk(clk), .en(en), .a(d3[tcit_pkg::D_UX]), .b(s3[tcit_pkg::S_VV]), .p(t_uxv));
  tcit_mul #(.AW(DFW), .BW(SW)) u_mul_vxu (
    .clk(clk), .en(en), .a(d3[tcit_pkg::D_VX]), .b(s3[tcit_pkg::S_UU]), .p(t_vxu));
  tcit_mul #(.AW(SW), .BW(SW)) u_mul_da (
    .clk(clk), .en(en), .a(s3[tcit_pkg::S_AL]), .b(s3[tcit_pkg::S_M1]), .p(t_a));
  tcit_mul #(.AW(SW), .BW(SW)) u_mul_db (
    .clk(clk), .en(en), .a(s3[tcit_pkg::S_BL]), .b(s3[tcit_pkg::S_M2]), .p(t_b));
  tcit_mul #(.AW(SW), .BW(SW)) u_mul_dc (
    .clk(clk), .en(en), .a(s3[tcit_pkg::S_CL]), .b(s3[tcit_pkg::S_M3]), .p(t_c));

  assign det_c = DTW'(t_a) + DTW'(t_b) + DTW'(t_c);

  always_ff @(posedge clk) begin
    if (en) begin
      den4    <= den3;
      den5    <= den4;
      den6    <= den5;
      nx6     <= NW'(t_axd) + NW'(t_vyu) - NW'(t_uyv);
      ny6     <= NW'(t_ayd) + NW'(t_uxv) - NW'(t_vxu);
      det_pos <= !det_c[DTW-1] && (det_c != '0);
      det_neg <= det_c[DTW-1];
    end
  end

  tcit_div #(.NW(NW), .DW(DENW)) u_div_x (
    .clk(clk), .en(en), .num(nx6), .den(den6), .quo(quo_x), .sat(sat_x));
  tcit_div #(.NW(NW), .DW(DENW)) u_div_y (
    .clk(clk), .en(en), .num(ny6), .den(den6), .quo(quo_y), .sat(sat_y));

  assign cross_mag = s3[tcit_pkg::S_CROSS][SW-1] ? SW'(-s3[tcit_pkg::S_CROSS])
                                                 : SW'(s3[tcit_pkg::S_CROSS]);

  always_comb begin
    side_c.area      = tcit_pkg::AREA_W'(cross_mag);
    side_c.degen     = (s3[tcit_pkg::S_CROSS] == '0);
    side_c.cross_neg = s3[tcit_pkg::S_CROSS][SW-1];
    side_c.in_tri    =
      (!s3[tcit_pkg::S_Z1][SW-1] && s3[tcit_pkg::S_Z1] != '0 &&
       !s3[tcit_pkg::S_Z2][SW-1] && s3[tcit_pkg::S_Z2] != '0 &&
       !s3[tcit_pkg::S_Z3][SW-1] && s3[tcit_pkg::S_Z3] != '0) ||
      (s3[tcit_pkg::S_Z1][SW-1] && s3[tcit_pkg::S_Z2][SW-1] && s3[tcit_pkg::S_Z3][SW-1]);
    side_c.in_circle = 1'b0;
  end

  always_comb begin
    side6_c           = side1[2];
    side6_c.in_circle = !side1[2].degen && (side1[2].cross_neg ? det_neg : det_pos);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1[0] <= side_c;
      side1[1] <= side1[0];
      side1[2] <= side1[1];
      side2[0] <= side6_c;
      for (int k = 1; k < DL; k++) begin
        side2[k] <= side2[k-1];
      end
    end
  end

  assign side_o = side2[DL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      center_x         <= side_o.degen ? '0 : quo_x;
      center_y         <= side_o.degen ? '0 : quo_y;
      center_saturated <= !side_o.degen && (sat_x || sat_y);
      degenerate       <= side_o.degen;
      in_circle        <= side_o.in_circle;
      in_triangle      <= side_o.in_tri;
      twice_area       <= side_o.area;
    end
  end

`ifndef SYNTHESIS
  a_stall_only: assert property (@(posedge clk)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> center_x == 0 && center_y == 0 &&
      !center_saturated && !in_circle && twice_area == 0)
    else $error("collinear word with nonzero center or flags");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && center_saturated |->
      center_x == tcit_pkg::CENTER_MAX || center_x == tcit_pkg::CENTER_MIN ||
      center_y == tcit_pkg::CENTER_MAX || center_y == tcit_pkg::CENTER_MIN)
    else $error("saturation flag without a clamped coordinate");
`endif

endmodule
